### hdl/dsa_pkg.sv
// Shared types and constants for the descriptor slot allocator.
// Holds the command and result structs, opcode and status codes, and sizes.
// No dependencies.
`timescale 1ns / 1ps

package dsa_pkg;

  localparam int unsigned MAX_SLOTS = 4096;
  localparam int unsigned SLOT_W    = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W     = SLOT_W + 1;
  localparam int unsigned HANDLE_W  = 64;
  localparam int unsigned STRIDE_W  = 16;
  localparam int unsigned CAP_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_STEPS = HANDLE_W;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_REL_IDX = 2'd1,
    OP_REL_HND = 2'd2,
    OP_REINIT  = 2'd3
  } dsa_op_e;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
  localparam logic [1:0] ST_REJECT     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 2'd3;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd32;

  typedef struct packed {
    dsa_op_e             opcode;
    logic [11:0]         slot_index;
    logic [HANDLE_W-1:0] cpu_handle_in;
    logic [HANDLE_W-1:0] gpu_handle_in;
  } dsa_cmd_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [11:0]         slot_out;
    logic [HANDLE_W-1:0] cpu_handle_out;
    logic [HANDLE_W-1:0] gpu_handle_out;
    logic [12:0]         free_count;
  } dsa_result_t;

endpackage

### hdl/dsa_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 16-bit divisor.
// Used by the allocator to turn a handle offset into a slot index.
// Depends on dsa_pkg.
`timescale 1ns / 1ps

module dsa_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [dsa_pkg::HANDLE_W-1:0]   dividend_i,
  input  logic [dsa_pkg::STRIDE_W-1:0]   divisor_i,
  output logic                           done_o,
  output logic [dsa_pkg::HANDLE_W-1:0]   quotient_o,
  output logic [dsa_pkg::STRIDE_W-1:0]   remainder_o
);
  import dsa_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  logic                run_q;
  logic                done_q;
  logic [STEP_W-1:0]   cnt_q;
  logic [HANDLE_W-1:0] dvd_q;
  logic [STRIDE_W-1:0] rem_q;
  logic [STRIDE_W-1:0] div_q;

  logic [STRIDE_W:0]   trial;
  logic [STRIDE_W:0]   diff;
  logic                fits;

  // The partial remainder stays below the divisor, so it fits in 16 bits.
  assign trial = {rem_q, dvd_q[HANDLE_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= run_q && !start_i && (cnt_q == STEP_W'(DIV_STEPS - 1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        dvd_q <= dividend_i;
        rem_q <= '0;
        div_q <= divisor_i;
      end else if (run_q) begin
        dvd_q <= {dvd_q[HANDLE_W-2:0], fits};
        rem_q <= fits ? diff[STRIDE_W-1:0] : trial[STRIDE_W-1:0];
        cnt_q <= cnt_q + STEP_W'(1);
        if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

### hdl/descriptor_slot_allocator.sv
// Descriptor slot allocator: LIFO free-index stack and per-slot free flags in
// block RAM. Release by handle pair runs two 64-step dividers side by side, and
// reinit writes one slot per cycle over the whole pool. One item at a time;
// busy is high until the result strobe, which the receiver cannot stall.
// Reset clears control state; the stacks need no clearing pass.
`timescale 1ns / 1ps

module descriptor_slot_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  dsa_pkg::dsa_cmd_t               cmd_i,
  output logic                            result_valid_o,
  output dsa_pkg::dsa_result_t            result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dsa_pkg::HANDLE_W-1:0]    cfg_data_i
);
  import dsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_A1,
    S_A2,
    S_A3,
    S_A4,
    S_R1,
    S_R2,
    S_HDIV,
    S_SWEEP
  } state_e;

  // Configuration registers.
  logic [CAP_W-1:0]    capacity_q;
  logic [HANDLE_W-1:0] cpu_base_q;
  logic [HANDLE_W-1:0] gpu_base_q;
  logic [STRIDE_W-1:0] stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= '0;
      cpu_base_q <= '0;
      gpu_base_q <= '0;
      stride_q   <= STRIDE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CAPACITY: capacity_q <= cfg_data_i[CAP_W-1:0];
        CFG_CPU_BASE: cpu_base_q <= cfg_data_i;
        CFG_GPU_BASE: gpu_base_q <= cfg_data_i;
        CFG_STRIDE:   stride_q   <= cfg_data_i[STRIDE_W-1:0];
        default:      ;
      endcase
    end
  end

  // Register writes wait until no transaction is in flight.
  assign cfg_ready_o = !busy;

  // Control state.
  state_e                      state_q, state_d;
  dsa_cmd_t                    cmd_q, cmd_d;
  logic [CNT_W-1:0]            depth_q, depth_d;
  logic [CNT_W-1:0]            act_cap_q, act_cap_d;
  logic [SLOT_W-1:0]           idx_q, idx_d;
  logic [SLOT_W-1:0]           sweep_q, sweep_d;
  logic [SLOT_W+STRIDE_W-1:0]  prod_q, prod_d;
  logic                        res_valid_q, res_valid_d;
  dsa_result_t                 res_q, res_d;

  // Memory ports.
  logic                stk_we;
  logic [SLOT_W-1:0]   stk_waddr;
  logic [SLOT_W-1:0]   stk_wdata;
  logic [SLOT_W-1:0]   stk_raddr;
  logic [SLOT_W-1:0]   stk_rdata_q;
  logic                sf_we;
  logic [SLOT_W-1:0]   sf_waddr;
  logic                sf_wdata;
  logic [SLOT_W-1:0]   sf_raddr;
  logic                sf_rdata_q;

  logic [SLOT_W-1:0]   stk_mem [MAX_SLOTS];
  logic                sf_mem  [MAX_SLOTS];

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sf_we) begin
      sf_mem[sf_waddr] <= sf_wdata;
    end
    sf_rdata_q <= sf_mem[sf_raddr];
  end

  // Handle-to-index dividers, one per handle.
  logic                div_start;
  logic [HANDLE_W-1:0] cpu_off;
  logic [HANDLE_W-1:0] gpu_off;
  logic                div_done;
  logic                gpu_div_done;
  logic [HANDLE_W-1:0] cpu_quot;
  logic [HANDLE_W-1:0] gpu_quot;
  logic [STRIDE_W-1:0] cpu_rem;
  logic [STRIDE_W-1:0] gpu_rem;

  assign cpu_off = cmd_q.cpu_handle_in - cpu_base_q;
  assign gpu_off = cmd_q.gpu_handle_in - gpu_base_q;

  dsa_div u_cpu_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (cpu_off),
    .divisor_i   (stride_q),
    .done_o      (div_done),
    .quotient_o  (cpu_quot),
    .remainder_o (cpu_rem)
  );

  dsa_div u_gpu_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (gpu_off),
    .divisor_i   (stride_q),
    .done_o      (gpu_div_done),
    .quotient_o  (gpu_quot),
    .remainder_o (gpu_rem)
  );

  logic cpu_q_ok;
  logic gpu_q_ok;

  assign cpu_q_ok = (cpu_rem == '0) && (cpu_quot[HANDLE_W-1:CNT_W] == '0)
                    && (cpu_quot[CNT_W-1:0] < act_cap_q);
  assign gpu_q_ok = (gpu_rem == '0) && (gpu_quot[HANDLE_W-1:CNT_W] == '0)
                    && (gpu_quot[CNT_W-1:0] < act_cap_q);

  // The allocate path reads the free flag of the index just popped.
  assign stk_raddr = depth_q[SLOT_W-1:0];
  assign sf_raddr  = (state_q == S_A2) ? stk_rdata_q : idx_q;

  logic                emit;
  logic [1:0]          emit_status;
  logic [HANDLE_W-1:0] emit_cpu;
  logic [HANDLE_W-1:0] emit_gpu;
  logic [SLOT_W-1:0]   emit_slot;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    depth_d     = depth_q;
    act_cap_d   = act_cap_q;
    idx_d       = idx_q;
    sweep_d     = sweep_q;
    prod_d      = prod_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    stk_we      = 1'b0;
    stk_waddr   = depth_q[SLOT_W-1:0];
    stk_wdata   = idx_q;
    sf_we       = 1'b0;
    sf_waddr    = idx_q;
    sf_wdata    = 1'b1;
    div_start   = 1'b0;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_slot   = '0;
    emit_cpu    = '0;
    emit_gpu    = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d   = cmd_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (cmd_q.opcode)
          OP_ALLOC: begin
            if (depth_q == '0) begin
              emit        = 1'b1;
              emit_status = ST_ALLOC_FAIL;
            end else begin
              depth_d = depth_q - CNT_W'(1);
              state_d = S_A1;
            end
          end
          OP_REL_IDX: begin
            idx_d   = cmd_q.slot_index;
            state_d = S_R1;
          end
          OP_REL_HND: begin
            if (stride_q == '0 || cmd_q.cpu_handle_in < cpu_base_q
                || cmd_q.gpu_handle_in < gpu_base_q) begin
              emit        = 1'b1;
              emit_status = ST_REJECT;
            end else begin
              div_start = 1'b1;
              state_d   = S_HDIV;
            end
          end
          OP_REINIT: begin
            if (capacity_q > CAP_W'(MAX_SLOTS)) begin
              act_cap_d = CNT_W'(MAX_SLOTS);
            end else begin
              act_cap_d = CNT_W'(capacity_q);
            end
            sweep_d = '0;
            state_d = S_SWEEP;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_A1: state_d = S_A2;
      S_A2: begin
        idx_d   = stk_rdata_q;
        state_d = S_A3;
      end
      S_A3: begin
        // A bad entry stays popped.
        if ({1'b0, idx_q} >= act_cap_q || !sf_rdata_q) begin
          emit        = 1'b1;
          emit_status = ST_ALLOC_FAIL;
        end else begin
          sf_we    = 1'b1;
          sf_wdata = 1'b0;
          prod_d   = {{STRIDE_W{1'b0}}, idx_q} * {{SLOT_W{1'b0}}, stride_q};
          state_d  = S_A4;
        end
      end
      S_A4: begin
        emit      = 1'b1;
        emit_slot = idx_q;
        emit_cpu  = cpu_base_q + HANDLE_W'(prod_q);
        emit_gpu  = gpu_base_q + HANDLE_W'(prod_q);
      end
      S_HDIV: begin
        if (div_done && gpu_div_done) begin
          if (cpu_q_ok && gpu_q_ok
              && cpu_quot[SLOT_W-1:0] == gpu_quot[SLOT_W-1:0]) begin
            idx_d   = cpu_quot[SLOT_W-1:0];
            state_d = S_R1;
          end else begin
            emit        = 1'b1;
            emit_status = ST_REJECT;
          end
        end
      end
      S_R1: state_d = S_R2;
      S_R2: begin
        emit = 1'b1;
        if ({1'b0, idx_q} >= act_cap_q || sf_rdata_q
            || depth_q >= CNT_W'(MAX_SLOTS)) begin
          emit_status = ST_REJECT;
        end else begin
          sf_we   = 1'b1;
          stk_we  = 1'b1;
          depth_d = depth_q + CNT_W'(1);
        end
      end
      S_SWEEP: begin
        sf_we     = 1'b1;
        sf_waddr  = sweep_q;
        stk_waddr = sweep_q;
        stk_wdata = SLOT_W'(act_cap_q - CNT_W'(1) - {1'b0, sweep_q});
        stk_we    = ({1'b0, sweep_q} < act_cap_q);
        sweep_d   = sweep_q + SLOT_W'(1);
        if (sweep_q == SLOT_W'(MAX_SLOTS - 1)) begin
          depth_d = act_cap_q;
          emit    = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (emit) begin
      state_d              = S_IDLE;
      res_valid_d          = 1'b1;
      res_d.status         = emit_status;
      res_d.slot_out       = emit_slot;
      res_d.cpu_handle_out = emit_cpu;
      res_d.gpu_handle_out = emit_gpu;
      res_d.free_count     = depth_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      act_cap_q   <= '0;
      sweep_q     <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      act_cap_q   <= act_cap_d;
      sweep_q     <= sweep_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    prod_q <= prod_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

### hdl/dsa_checker.sv
// Port-level checks for the descriptor slot allocator, attached by bind.
// Depends on dsa_pkg and on the top-level port names.
`timescale 1ns / 1ps

module dsa_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  result_valid_o,
  input dsa_pkg::dsa_result_t  result_o
);
  import dsa_pkg::*;

  // One transaction in flight, so the result strobe never stays high back to back.
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while still busy");

  a_fail_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != ST_OK) |->
      (result_o.slot_out == '0 && result_o.cpu_handle_out == '0
       && result_o.gpu_handle_out == '0))
    else $error("failed transaction carries a slot or handle");

  a_status_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      ((result_o.status == ST_OK || result_o.status == ST_ALLOC_FAIL
        || result_o.status == ST_REJECT)
       && result_o.free_count <= 13'(MAX_SLOTS)))
    else $error("bad status or free count out of range");

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (.*);

### tb/sv/dsa_slot_checker.sv
// Scoreboard for the descriptor slot allocator: follows the command, result and
// register-write channels, predicts every result and compares it field by field.
// Depends on dsa_pkg for the command and result structs and the code constants.
`timescale 1ns / 1ps

module dsa_slot_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  dsa_pkg::dsa_cmd_t             cmd_i,
  input  logic                          rsp_valid_i,
  input  dsa_pkg::dsa_result_t          rsp_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [dsa_pkg::HANDLE_W-1:0]  cfg_data_i,
  output int unsigned                   pending_o,
  output int unsigned                   fail_count_o
);
  import dsa_pkg::*;

  // Register shadows; capacity only takes effect at a reinit.
  logic [CAP_W-1:0]    cap_reg;
  logic [HANDLE_W-1:0] cpu_base_reg;
  logic [HANDLE_W-1:0] gpu_base_reg;
  logic [STRIDE_W-1:0] stride_reg;

  // Shadow of the allocator's pool.
  logic [SLOT_W-1:0] pool_stack [MAX_SLOTS];
  logic [CNT_W-1:0]  pool_depth;
  bit                slot_is_free [MAX_SLOTS];
  logic [CNT_W-1:0]  live_cap;

  dsa_result_t expected_results [$];
  dsa_result_t want;
  int unsigned errors = 0;

  assign fail_count_o = errors;

  function automatic void check_field(input string name, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      errors++;
    end
  endfunction

  // A handle maps to a slot only if it sits on a stride boundary at or above
  // its base and the resulting index is inside the active pool.
  function automatic bit handle_to_slot(input logic [63:0] handle, input logic [63:0] base,
                                        output logic [63:0] slot);
    logic [63:0] offset;
    slot = '0;
    if (stride_reg == '0 || handle < base) return 1'b0;
    offset = handle - base;
    if (offset % 64'(stride_reg) != 64'd0) return 1'b0;
    slot = offset / 64'(stride_reg);
    return slot < 64'(live_cap);
  endfunction

  function automatic logic [1:0] release_slot(input logic [63:0] slot);
    if (slot >= 64'(live_cap) || slot_is_free[slot[SLOT_W-1:0]]) return ST_REJECT;
    if (pool_depth >= MAX_SLOTS) return ST_REJECT;
    slot_is_free[slot[SLOT_W-1:0]] = 1'b1;
    pool_stack[pool_depth[SLOT_W-1:0]] = slot[SLOT_W-1:0];
    pool_depth++;
    return ST_OK;
  endfunction

  function automatic dsa_result_t predict_outcome(input dsa_cmd_t c);
    dsa_result_t       r;
    logic [63:0]       cpu_slot;
    logic [63:0]       gpu_slot;
    bit                cpu_ok;
    bit                gpu_ok;
    logic [SLOT_W-1:0] popped;
    int                k;
    r = '0;
    r.status = ST_OK;
    case (c.opcode)
      OP_ALLOC: begin
        if (pool_depth == '0) begin
          r.status = ST_ALLOC_FAIL;
        end else begin
          // A bad entry stays popped even though the allocation fails.
          pool_depth--;
          popped = pool_stack[pool_depth[SLOT_W-1:0]];
          if (CNT_W'(popped) >= live_cap || !slot_is_free[popped]) begin
            r.status = ST_ALLOC_FAIL;
          end else begin
            slot_is_free[popped] = 1'b0;
            r.slot_out = popped;
            r.cpu_handle_out = cpu_base_reg + 64'(popped) * 64'(stride_reg);
            r.gpu_handle_out = gpu_base_reg + 64'(popped) * 64'(stride_reg);
          end
        end
      end
      OP_REL_IDX: r.status = release_slot(64'(c.slot_index));
      OP_REL_HND: begin
        cpu_ok = handle_to_slot(c.cpu_handle_in, cpu_base_reg, cpu_slot);
        gpu_ok = handle_to_slot(c.gpu_handle_in, gpu_base_reg, gpu_slot);
        if (cpu_ok && gpu_ok && cpu_slot == gpu_slot) r.status = release_slot(cpu_slot);
        else r.status = ST_REJECT;
      end
      default: begin
        live_cap = (cap_reg > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(cap_reg);
        for (k = 0; k < MAX_SLOTS; k++) slot_is_free[k] = 1'b1;
        // Slot zero ends up on top of the stack.
        for (k = 0; k < live_cap; k++) pool_stack[k] = SLOT_W'(live_cap - 1 - k);
        pool_depth = live_cap;
      end
    endcase
    r.free_count = pool_depth;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_reg = '0;
      cpu_base_reg = '0;
      gpu_base_reg = '0;
      stride_reg = STRIDE_RESET;
      pool_depth = '0;
      live_cap = '0;
      for (int k = 0; k < MAX_SLOTS; k++) slot_is_free[k] = 1'b1;
      expected_results.delete();
    end else begin
      // The result of one transaction may retire at the same edge that accepts
      // the next command, so compare before predicting.
      if (rsp_valid_i) begin
        if (expected_results.size() == 0) begin
          $error("result strobe with no outstanding command");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(want.status), 64'(rsp_i.status));
          check_field("slot_out", 64'(want.slot_out), 64'(rsp_i.slot_out));
          check_field("cpu_handle_out", want.cpu_handle_out, rsp_i.cpu_handle_out);
          check_field("gpu_handle_out", want.gpu_handle_out, rsp_i.gpu_handle_out);
          check_field("free_count", 64'(want.free_count), 64'(rsp_i.free_count));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CAPACITY: cap_reg = cfg_data_i[CAP_W-1:0];
          CFG_CPU_BASE: cpu_base_reg = cfg_data_i;
          CFG_GPU_BASE: gpu_base_reg = cfg_data_i;
          default:      stride_reg = cfg_data_i[STRIDE_W-1:0];
        endcase
      end
      if (start_i && !busy_i) begin
        expected_results.insert(expected_results.size(), predict_outcome(cmd_i));
      end
    end
    pending_o <= expected_results.size();
  end

endmodule

### tb/sv/tb_descriptor_slot_allocator.sv
// Top of the descriptor slot allocator bench: clock, reset, command and register
// stimulus, watchdog and verdict. Results are judged by dsa_slot_checker.
// Depends on dsa_pkg, descriptor_slot_allocator and dsa_slot_checker.
`timescale 1ns / 1ps

module tb_descriptor_slot_allocator;
  import dsa_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned PHASE_ITEMS    = 190;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  dsa_cmd_t             cmd;
  logic                 rsp_valid;
  dsa_result_t          rsp;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [HANDLE_W-1:0]  cfg_data;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned quiet_cycles = 0;

  // What the stimulus believes about the block; only used to shape commands.
  logic [CAP_W-1:0]    cfg_cap = '0;
  logic [HANDLE_W-1:0] cfg_cpu = '0;
  logic [HANDLE_W-1:0] cfg_gpu = '0;
  logic [STRIDE_W-1:0] cfg_stride = STRIDE_RESET;
  int unsigned         live_slots = 0;
  int unsigned         held [$];
  dsa_op_e             sent_ops [$];
  dsa_op_e             done_op;
  bit                  idle_on = 1'b1;

  descriptor_slot_allocator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd),
    .result_valid_o (rsp_valid),
    .result_o       (rsp),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  dsa_slot_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd),
    .rsp_valid_i  (rsp_valid),
    .rsp_i        (rsp),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Keep the list of allocated slots current so that most releases are legal.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid && sent_ops.size() > 0) begin
      done_op = sent_ops.pop_front();
      if (done_op == OP_REINIT) held.delete();
      else if (done_op == OP_ALLOC && rsp.status == ST_OK) held.insert(held.size(), rsp.slot_out);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || rsp_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL descriptor_slot_allocator");
      $finish;
    end
  end

  function automatic logic [63:0] slot_handle(input logic [63:0] base, input int unsigned slot);
    return base + 64'(slot) * 64'(cfg_stride);
  endfunction

  function automatic dsa_cmd_t request(input dsa_op_e op, input int unsigned slot,
                                       input logic [63:0] cpu_h, input logic [63:0] gpu_h);
    dsa_cmd_t c;
    c.opcode = op;
    c.slot_index = 12'(slot);
    c.cpu_handle_in = cpu_h;
    c.gpu_handle_in = gpu_h;
    return c;
  endfunction

  // Mostly allocate/release traffic on slots that are really held, with some
  // double frees, malformed handle pairs, random handles and rare reinits.
  function automatic dsa_cmd_t next_request();
    dsa_cmd_t    c;
    int unsigned pick;
    int unsigned pos;
    int unsigned s;
    c = request(OP_ALLOC, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      c.opcode = OP_ALLOC;
    end else if (pick < 72) begin
      if (held.size() > 0) begin
        pos = $urandom_range(0, held.size() - 1);
        s = held[pos];
        held.delete(pos);
        if (pick < 56) begin
          c.opcode = OP_REL_IDX;
          c.slot_index = 12'(s);
        end else begin
          c.opcode = OP_REL_HND;
          c.cpu_handle_in = slot_handle(cfg_cpu, s);
          c.gpu_handle_in = slot_handle(cfg_gpu, s);
        end
      end
    end else if (pick < 80) begin
      c.opcode = OP_REL_IDX;
      if (pick < 77 && live_slots > 0) c.slot_index = 12'($urandom_range(0, live_slots - 1));
      for (pos = 0; pos < held.size(); pos++) begin
        if (held[pos] == c.slot_index) begin
          held.delete(pos);
          break;
        end
      end
    end else if (pick < 90) begin
      c.opcode = OP_REL_HND;
      s = (held.size() > 0) ? held[$urandom_range(0, held.size() - 1)]
                            : $urandom_range(0, MAX_SLOTS - 1);
      c.cpu_handle_in = slot_handle(cfg_cpu, s);
      c.gpu_handle_in = slot_handle(cfg_gpu, s);
      case (pick % 4)
        0: c.cpu_handle_in = c.cpu_handle_in + 64'd1;
        1: c.gpu_handle_in = slot_handle(cfg_gpu, s + 1);
        2: c.cpu_handle_in = cfg_cpu - 64'd1;
        default: begin
          c.cpu_handle_in = slot_handle(cfg_cpu, live_slots);
          c.gpu_handle_in = slot_handle(cfg_gpu, live_slots);
        end
      endcase
    end else if (pick < 98) begin
      c.opcode = OP_REL_HND;
    end else begin
      c.opcode = OP_REINIT;
    end
    return c;
  endfunction

  // Leaves start high on return so that a following command can go out
  // back to back; whoever stops sending lowers it.
  task automatic issue(input dsa_cmd_t c);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    cmd <= c;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sent_ops.insert(sent_ops.size(), c.opcode);
    if (c.opcode == OP_REINIT) live_slots = (cfg_cap > MAX_SLOTS) ? MAX_SLOTS : cfg_cap;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_CAPACITY: cfg_cap = value[CAP_W-1:0];
      CFG_CPU_BASE: cfg_cpu = value;
      CFG_GPU_BASE: cfg_gpu = value;
      default:      cfg_stride = value[STRIDE_W-1:0];
    endcase
  endtask

  task automatic configure(input logic [CAP_W-1:0] cap, input logic [63:0] cpu_b,
                           input logic [63:0] gpu_b, input logic [STRIDE_W-1:0] stride);
    wait_drained();
    write_reg(CFG_CAPACITY, 64'(cap));
    write_reg(CFG_CPU_BASE, cpu_b);
    write_reg(CFG_GPU_BASE, gpu_b);
    write_reg(CFG_STRIDE, 64'(stride));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    cmd <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fresh after reset: empty stack and a zero-sized pool.
    issue(request(OP_ALLOC, 0, '0, '0));
    issue(request(OP_REL_IDX, 0, '0, '0));
    issue(request(OP_REL_HND, 0, '0, '0));
    issue(request(OP_REINIT, 0, '0, '0));

    // Four slots; the GPU handles wrap past zero from slot one on.
    configure(13'd4, 64'h1000, 64'hFFFF_FFFF_FFFF_FFC0, 16'd64);
    issue(request(OP_REINIT, 0, '0, '0));
    repeat (5) issue(request(OP_ALLOC, 0, '0, '0));
    issue(request(OP_REL_IDX, 2, '0, '0));
    issue(request(OP_REL_IDX, 2, '0, '0));
    issue(request(OP_REL_IDX, 4095, '1, '1));
    issue(request(OP_REL_HND, 0, slot_handle(cfg_cpu, 1), slot_handle(cfg_gpu, 1)));
    issue(request(OP_REL_HND, 0, cfg_cpu - 64'd1, slot_handle(cfg_gpu, 0)));
    issue(request(OP_REL_HND, 0, slot_handle(cfg_cpu, 3) + 64'd1, slot_handle(cfg_gpu, 3)));
    issue(request(OP_REL_HND, 0, slot_handle(cfg_cpu, 3), slot_handle(cfg_gpu, 0)));
    issue(request(OP_REL_HND, 0, slot_handle(cfg_cpu, 4), slot_handle(cfg_gpu, 4)));
    issue(request(OP_REL_HND, 0, slot_handle(cfg_cpu, 3), slot_handle(cfg_gpu, 3)));
    issue(request(OP_REL_HND, 4095, '1, '1));
    issue(request(OP_ALLOC, 0, '0, '0));

    // A zero stride rejects every handle release.
    wait_drained();
    write_reg(CFG_STRIDE, 64'd0);
    cfg_valid <= 1'b0;
    issue(request(OP_REL_HND, 0, cfg_cpu, cfg_gpu));
    issue(request(OP_REL_IDX, 0, '0, '0));

    // An oversized capacity saturates to the whole pool.
    wait_drained();
    write_reg(CFG_CAPACITY, 64'h1FFF);
    cfg_valid <= 1'b0;
    issue(request(OP_REINIT, 0, '0, '0));
    issue(request(OP_ALLOC, 0, '0, '0));

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(13'd16, {$urandom, $urandom}, {$urandom, $urandom}, 16'd32);
        1: configure(13'd1, 64'd0, '1, 16'd1);
        2: configure(13'd4096, 64'hFFFF_FFFF_FFFF_F000, {$urandom, $urandom}, 16'hFFFF);
        3: configure(13'h1FFF, {$urandom, $urandom}, {$urandom, $urandom},
                     16'($urandom_range(1, 65535)));
        4: configure(13'd0, {$urandom, $urandom}, {$urandom, $urandom}, 16'd0);
        5: configure(13'($urandom_range(2, 64)), {$urandom, $urandom},
                     {$urandom, $urandom}, 16'd0);
        6: configure(13'($urandom_range(2, 200)), {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom_range(1, 300)));
        default: configure(13'($urandom_range(1, 48)), {$urandom, $urandom},
                           {$urandom, $urandom}, 16'($urandom_range(1, 64)));
      endcase
      // Phase six keeps the previous pool so that new bases and stride act on
      // slots that are already held.
      if (ph != 6) issue(request(OP_REINIT, $urandom, {$urandom, $urandom}, '0));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) idle_on = (ph != 7) && ($urandom_range(0, 2) != 0);
        if (ph == 3 && n == PHASE_ITEMS / 2) wait_drained();
        issue(next_request());
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS descriptor_slot_allocator");
    end else begin
      $display("FAIL descriptor_slot_allocator");
    end
    $finish;
  end

endmodule
